[rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants, types and helpers for the ray/shape intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EPS_BITS       = 16;
    localparam int TAG_BITS       = 8;
    localparam int MUL_CHUNK      = 32;

    localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

    localparam logic MODE_SPHERE = 1'b0;
    localparam logic MODE_PLANE  = 1'b1;

    typedef enum logic [1:0] {
        HITS_NONE   = 2'd0,
        HITS_PLANE  = 2'd1,
        HITS_SPHERE = 2'd2
    } t_hits;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[rtl/rsi_mul.sv]
// ----------------------------------------------------------------------------
// rsi_mul
// Unsigned pipelined multiplier: 32x32 partial products, then a summing stage.
// ----------------------------------------------------------------------------
module rsi_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);
    import rsi_pkg::*;

    localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int XW = (NA + NB) * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0] a_ext;
    logic [NB*MUL_CHUNK-1:0] b_ext;
    logic [2*MUL_CHUNK-1:0]  r_pp [NA*NB];
    logic [XW-1:0]           n_sum;
    logic [XW-1:0]           r_sum;

    assign a_ext = (NA*MUL_CHUNK)'(i_a);
    assign b_ext = (NB*MUL_CHUNK)'(i_b);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i*NB+j] <= a_ext[i*MUL_CHUNK +: MUL_CHUNK]
                              * b_ext[j*MUL_CHUNK +: MUL_CHUNK];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (XW'(r_pp[i*NB+j]) << (MUL_CHUNK * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_p = r_sum[WA+WB-1:0];

endmodule

[rtl/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int NW   = 66,
    parameter int DENW = 64,
    parameter int QW   = 32,
    parameter int FB   = 16
) (
    input  logic            i_clk,
    input  logic [NW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    input  logic            i_neg,
    output logic [QW-1:0]   o_q,
    output logic            o_ovf,
    output logic            o_neg
);
    import rsi_pkg::*;

    localparam int XW  = NW + FB;
    localparam int RMW = imax(XW, DENW + QW) + 1;

    logic [RMW-1:0]  w_x;
    logic [RMW-1:0]  w_dlim;
    logic [RMW-1:0]  r_rem [QW+1];
    logic [DENW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];
    logic            r_ovf [QW+1];
    logic            r_neg [QW+1];

    assign w_x    = RMW'(i_num) << FB;
    assign w_dlim = RMW'(i_den) << QW;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_x;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (w_x >= w_dlim);
        r_neg[0] <= i_neg;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RMW-1:0] w_sub;
        logic           w_ge;

        assign w_sub = RMW'(r_den[k-1]) << (QW - k);
        assign w_ge  = (r_rem[k-1] >= w_sub);

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? (r_rem[k-1] - w_sub) : r_rem[k-1];
            r_q[k]   <= r_q[k-1] | (QW'(w_ge) << (QW - k));
            r_den[k] <= r_den[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_neg = r_neg[QW];

endmodule

[rtl/ray_shape_intersection_top.sv]
// ----------------------------------------------------------------------------
// ray_shape_intersection_top
// Ray against unit sphere or plane y=0, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// pipeline: 10 + RW + COORD_BITS register stages, RW = sqrt pipeline depth
// throughput: one item per cycle while busy is low; sqrt and divider are one-bit-per-stage
// reset: synchronous active low, clears valids and epsilon to 1; busy is high
//   in reset and the cycle after it, then stays low; results cannot be stalled
module ray_shape_intersection_top #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsi_pkg::EPS_BITS-1:0]  i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [rsi_pkg::TAG_BITS-1:0]  i_shape_tag,
    input  logic signed [COORD_BITS-1:0]  i_origin_x,
    input  logic signed [COORD_BITS-1:0]  i_origin_y,
    input  logic signed [COORD_BITS-1:0]  i_origin_z,
    input  logic signed [COORD_BITS-1:0]  i_dir_x,
    input  logic signed [COORD_BITS-1:0]  i_dir_y,
    input  logic signed [COORD_BITS-1:0]  i_dir_z,
    output logic                          o_valid,
    output logic [rsi_pkg::TAG_BITS-1:0]  o_tag_out,
    output logic [1:0]                    o_hit_count,
    output logic signed [COORD_BITS-1:0]  o_t_near,
    output logic signed [COORD_BITS-1:0]  o_t_far,
    output logic                          o_range_flag
);
    import rsi_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int PW  = 2 * CB;
    localparam int HW  = PW + 1;
    localparam int CMW = imax(PW, 2 * FB) + 1;
    localparam int CSW = CMW + 1;
    localparam int DMW = imax(4 * CB, PW + CMW) + 1;
    localparam int DSW = DMW + 1;
    localparam int RW  = (DMW + 1) / 2;
    localparam int RDW = 2 * RW;
    localparam int SRW = RW + 3;
    localparam int NMW = imax(PW, RW) + 1;
    localparam int NSW = NMW + 1;
    localparam int NSD = 7 + RW;
    localparam int NFN = CB + 2;
    localparam int LAT = 10 + RW + CB;

    localparam logic [CB-1:0] T_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] T_MAX = ~T_MIN;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                mode;
        logic                pl_hit;
        logic                pl_neg;
        logic [CB-1:0]       pl_num;
        logic [CB-1:0]       pl_den;
    } t_side;

    typedef struct packed {
        logic                 azero;
        logic                 cneg;
        logic [PW-1:0]        a;
        logic signed [HW-1:0] h;
    } t_sa;

    typedef struct packed {
        logic                 ok;
        logic                 azero;
        logic [PW-1:0]        a;
        logic signed [HW-1:0] h;
    } t_sb;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        t_hits               hits;
        logic                zflag;
    } t_fn;

    function automatic logic [CB:0] f_sat(input logic [CB-1:0] q, input logic ovf,
                                          input logic neg);
        logic          sat;
        logic [CB-1:0] v;
        sat = ovf | (neg ? (q > T_MIN) : q[CB-1]);
        if (neg) begin
            v = sat ? T_MIN : (~q + 1'b1);
        end else begin
            v = sat ? T_MAX : q;
        end
        return {sat, v};
    endfunction

    // control
    logic                r_busy;
    logic [EPS_BITS-1:0] r_eps;
    logic [LAT-1:0]      r_vld;

    // input stage
    logic signed [CB-1:0] w_o [3];
    logic signed [CB-1:0] w_d [3];
    logic [CB-1:0]        n_om [3];
    logic [CB-1:0]        n_dm [3];
    logic [CB-1:0]        r_om [3];
    logic [CB-1:0]        r_dm [3];
    logic [2:0]           r_hsg [3];
    t_side                n_sd;
    t_side                r_sd [NSD];

    // dot products
    logic [PW-1:0] w_dd [3];
    logic [PW-1:0] w_do [3];
    logic [PW-1:0] w_oo [3];

    logic [PW-1:0]         n_a;
    logic signed [HW-1:0]  n_h;
    logic signed [CSW-1:0] n_c;
    logic [PW-1:0]         r_hm;
    logic [CMW-1:0]        r_cm;
    t_sa                   r_sa [3];

    // discriminant
    logic [4*CB-1:0]       w_hh;
    logic [PW+CMW-1:0]     w_ac;
    logic signed [DSW-1:0] n_d;
    logic [RDW-1:0]        r_dmag;
    t_sb                   r_sb [RW+1];

    // square root
    logic [SRW-1:0] r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [RDW-1:0] r_rad  [RW];

    // numerators
    logic signed [NSW-1:0] w_near;
    logic signed [NSW-1:0] w_far;
    logic [NMW-1:0]        n_nn;
    logic [NMW-1:0]        n_nf;
    logic                  n_nn_neg;
    logic                  n_nf_neg;
    logic [PW-1:0]         n_den;
    logic [NMW-1:0]        r_nn;
    logic [NMW-1:0]        r_nf;
    logic                  r_nn_neg;
    logic                  r_nf_neg;
    logic [PW-1:0]         r_den;
    t_fn                   n_fn;
    t_fn                   r_fn [NFN];

    // division and output
    logic [CB-1:0] w_qn;
    logic [CB-1:0] w_qf;
    logic          w_ovn;
    logic          w_ovf;
    logic          w_ngn;
    logic          w_ngf;
    logic [CB:0]   w_sn;
    logic [CB:0]   w_sf;

    logic [TAG_BITS-1:0] n_tag;
    logic [1:0]          n_hits;
    logic [CB-1:0]       n_tn;
    logic [CB-1:0]       n_tf;
    logic                n_flag;
    logic [TAG_BITS-1:0] r_tag;
    logic [1:0]          r_hits;
    logic [CB-1:0]       r_tn;
    logic [CB-1:0]       r_tf;
    logic                r_flag;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_eps  <= EPS_RESET;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], start & ~r_busy};
        end
    end

    assign busy = r_busy;

    // ---------------- input stage ----------------
    assign w_o[0] = i_origin_x;
    assign w_o[1] = i_origin_y;
    assign w_o[2] = i_origin_z;
    assign w_d[0] = i_dir_x;
    assign w_d[1] = i_dir_y;
    assign w_d[2] = i_dir_z;

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            n_om[g] = w_o[g][CB-1] ? CB'(-w_o[g]) : CB'(w_o[g]);
            n_dm[g] = w_d[g][CB-1] ? CB'(-w_d[g]) : CB'(w_d[g]);
        end
        n_sd.tag    = i_shape_tag;
        n_sd.mode   = i_mode;
        n_sd.pl_hit = (w_d[1] != '0) && (n_dm[1] >= CB'(r_eps));
        n_sd.pl_neg = (w_o[1] != '0) && (w_o[1][CB-1] == w_d[1][CB-1]);
        n_sd.pl_num = n_om[1];
        n_sd.pl_den = n_dm[1];
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 3; g++) begin
            r_om[g] <= n_om[g];
            r_dm[g] <= n_dm[g];
            r_hsg[0][g] <= w_o[g][CB-1] ^ w_d[g][CB-1];
        end
        r_hsg[1] <= r_hsg[0];
        r_hsg[2] <= r_hsg[1];
        r_sd[0]  <= n_sd;
        for (int k = 1; k < NSD; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // ---------------- dot products ----------------
    for (genvar g = 0; g < 3; g++) begin : g_dot
        rsi_mul #(.WA(CB), .WB(CB)) u_dd (
            .i_clk (i_clk), .i_a (r_dm[g]), .i_b (r_dm[g]), .o_p (w_dd[g])
        );
        rsi_mul #(.WA(CB), .WB(CB)) u_do (
            .i_clk (i_clk), .i_a (r_dm[g]), .i_b (r_om[g]), .o_p (w_do[g])
        );
        rsi_mul #(.WA(CB), .WB(CB)) u_oo (
            .i_clk (i_clk), .i_a (r_om[g]), .i_b (r_om[g]), .o_p (w_oo[g])
        );
    end

    always_comb begin
        n_a = w_dd[0] + w_dd[1] + w_dd[2];
        n_h = '0;
        for (int g = 0; g < 3; g++) begin
            n_h = n_h + (r_hsg[2][g] ? -HW'(w_do[g]) : HW'(w_do[g]));
        end
        n_c = CSW'(w_oo[0]) + CSW'(w_oo[1]) + CSW'(w_oo[2]) - (CSW'(1) << (2 * FB));
    end

    always_ff @(posedge i_clk) begin
        r_hm          <= n_h[HW-1] ? PW'(-n_h) : PW'(n_h);
        r_cm          <= n_c[CSW-1] ? CMW'(-n_c) : CMW'(n_c);
        r_sa[0].azero <= (n_a == '0);
        r_sa[0].cneg  <= n_c[CSW-1];
        r_sa[0].a     <= n_a;
        r_sa[0].h     <= n_h;
        r_sa[1]       <= r_sa[0];
        r_sa[2]       <= r_sa[1];
    end

    // ---------------- discriminant ----------------
    rsi_mul #(.WA(PW), .WB(PW)) u_hh (
        .i_clk (i_clk), .i_a (r_hm), .i_b (r_hm), .o_p (w_hh)
    );
    rsi_mul #(.WA(PW), .WB(CMW)) u_ac (
        .i_clk (i_clk), .i_a (r_sa[0].a), .i_b (r_cm), .o_p (w_ac)
    );

    assign n_d = DSW'(w_hh) + (r_sa[2].cneg ? DSW'(w_ac) : -DSW'(w_ac));

    always_ff @(posedge i_clk) begin
        r_dmag      <= RDW'(n_d[DMW-1:0]);
        r_sb[0].ok  <= ~r_sa[2].azero & ~n_d[DSW-1];
        r_sb[0].azero <= r_sa[2].azero;
        r_sb[0].a   <= r_sa[2].a;
        r_sb[0].h   <= r_sa[2].h;
        for (int k = 1; k <= RW; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // ---------------- square root, one result bit a stage ----------------
    for (genvar k = 0; k < RW; k++) begin : g_sq
        logic [SRW-1:0] rem_in;
        logic [SRW-1:0] rem_sh;
        logic [SRW-1:0] trial;
        logic [RW-1:0]  root_in;
        logic [RDW-1:0] rad_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_dmag;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign rem_sh = {rem_in[SRW-3:0], rad_in[RDW-1 -: 2]};
        assign trial  = SRW'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (rem_sh >= trial) begin
                r_rem[k]  <= rem_sh - trial;
                r_root[k] <= {root_in[RW-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh;
                r_root[k] <= {root_in[RW-2:0], 1'b0};
            end
            r_rad[k] <= rad_in << 2;
        end
    end

    // ---------------- numerators, plane shares the near lane ----------------
    assign w_near = -NSW'(r_sb[RW].h) - NSW'(r_root[RW-1]);
    assign w_far  = -NSW'(r_sb[RW].h) + NSW'(r_root[RW-1]);

    always_comb begin
        n_fn.tag   = r_sd[NSD-1].tag;
        n_fn.zflag = 1'b0;
        n_nf       = w_far[NSW-1] ? NMW'(-w_far) : NMW'(w_far);
        n_nf_neg   = w_far[NSW-1];
        if (r_sd[NSD-1].mode == MODE_PLANE) begin
            n_nn       = NMW'(r_sd[NSD-1].pl_num);
            n_nn_neg   = r_sd[NSD-1].pl_neg;
            n_den      = PW'(r_sd[NSD-1].pl_den);
            n_fn.hits  = r_sd[NSD-1].pl_hit ? HITS_PLANE : HITS_NONE;
        end else begin
            n_nn       = w_near[NSW-1] ? NMW'(-w_near) : NMW'(w_near);
            n_nn_neg   = w_near[NSW-1];
            n_den      = r_sb[RW].a;
            n_fn.hits  = r_sb[RW].ok ? HITS_SPHERE : HITS_NONE;
            n_fn.zflag = r_sb[RW].azero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nn     <= n_nn;
        r_nf     <= n_nf;
        r_nn_neg <= n_nn_neg;
        r_nf_neg <= n_nf_neg;
        r_den    <= n_den;
        r_fn[0]  <= n_fn;
        for (int k = 1; k < NFN; k++) begin
            r_fn[k] <= r_fn[k-1];
        end
    end

    // ---------------- division ----------------
    rsi_div #(.NW(NMW), .DENW(PW), .QW(CB), .FB(FB)) u_div_near (
        .i_clk (i_clk), .i_num (r_nn), .i_den (r_den), .i_neg (r_nn_neg),
        .o_q (w_qn), .o_ovf (w_ovn), .o_neg (w_ngn)
    );
    rsi_div #(.NW(NMW), .DENW(PW), .QW(CB), .FB(FB)) u_div_far (
        .i_clk (i_clk), .i_num (r_nf), .i_den (r_den), .i_neg (r_nf_neg),
        .o_q (w_qf), .o_ovf (w_ovf), .o_neg (w_ngf)
    );

    // ---------------- saturation and result register ----------------
    assign w_sn = f_sat(w_qn, w_ovn, w_ngn);
    assign w_sf = f_sat(w_qf, w_ovf, w_ngf);

    always_comb begin
        n_tag  = r_fn[NFN-1].tag;
        n_hits = r_fn[NFN-1].hits;
        case (r_fn[NFN-1].hits)
            HITS_PLANE: begin
                n_tn   = w_sn[CB-1:0];
                n_tf   = '0;
                n_flag = w_sn[CB];
            end
            HITS_SPHERE: begin
                n_tn   = w_sn[CB-1:0];
                n_tf   = w_sf[CB-1:0];
                n_flag = w_sn[CB] | w_sf[CB];
            end
            default: begin
                n_tn   = '0;
                n_tf   = '0;
                n_flag = r_fn[NFN-1].zflag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_hits <= n_hits;
        r_tn   <= n_tn;
        r_tf   <= n_tf;
        r_flag <= n_flag;
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_tag_out    = r_tag;
    assign o_hit_count  = r_hits;
    assign o_t_near     = r_tn;
    assign o_t_far      = r_tf;
    assign o_range_flag = r_flag;

endmodule

[rtl/rsi_chk.sv]
// ----------------------------------------------------------------------------
// rsi_chk
// Port-level checks on the intersection results, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_chk #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic [1:0]                   o_hit_count,
    input logic signed [COORD_BITS-1:0] o_t_near,
    input logic signed [COORD_BITS-1:0] o_t_far
);
    import rsi_pkg::*;

    a_no_strobe_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_valid
    ) else $error("result strobe right after reset");

    a_hit_count_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_count == HITS_NONE || o_hit_count == HITS_PLANE ||
                     o_hit_count == HITS_SPHERE)
    ) else $error("hit count out of range");

    a_miss_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == HITS_NONE) |-> (o_t_near == '0 && o_t_far == '0)
    ) else $error("miss with nonzero distance");

    a_plane_far_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == HITS_PLANE) |-> (o_t_far == '0)
    ) else $error("plane hit with nonzero far distance");

    a_sphere_order: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == HITS_SPHERE) |-> (o_t_near <= o_t_far)
    ) else $error("sphere roots out of order");

endmodule

bind ray_shape_intersection_top rsi_chk #(.COORD_BITS(COORD_BITS)) u_rsi_chk (.*);

[verif/ray_shape_intersection_top_test.sv]
// ----------------------------------------------------------------------------
// ray_shape_intersection_top_test
// Drives rays at the sphere and plane intersection pipeline, predicts each
// result with wide exact integer math and checks every strobed result in order.
// ----------------------------------------------------------------------------
module ray_shape_intersection_top_test;
    import rsi_pkg::*;

    localparam int CB = 32;
    localparam int FB = 16;
    localparam int LATENCY = 106;

    typedef struct {
        logic [7:0]           tag;
        t_hits                hits;
        logic signed [CB-1:0] t_near;
        logic signed [CB-1:0] t_far;
        logic                 flag;
    } t_hit_result;

    typedef logic signed [255:0] t_wide;

    class hit_scoreboard;
        t_hit_result pending[$];
        int errors = 0;

        function automatic t_wide root_floor(t_wide v);
            t_wide r;
            t_wide c;
            r = 0;
            for (int i = 127; i >= 0; i--) begin
                c = r | (t_wide'(1) << i);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        function automatic logic signed [CB-1:0] sat_quot(t_wide num, t_wide den,
                                                            ref logic flag);
            t_wide q;
            t_wide mag;
            t_wide lim;
            mag = (num < 0) ? -num : num;
            q = (mag <<< FB) / den;
            lim = (num < 0) ? (t_wide'(1) <<< (CB - 1)) : ((t_wide'(1) <<< (CB - 1)) - 1);
            if (q > lim) begin
                q = lim;
                flag = 1'b1;
            end
            if (num < 0) q = -q;
            return q[CB-1:0];
        endfunction

        function void note_ray(logic mode, logic [7:0] tag, logic signed [CB-1:0] ox,
                               logic signed [CB-1:0] oy, logic signed [CB-1:0] oz,
                               logic signed [CB-1:0] dx, logic signed [CB-1:0] dy,
                               logic signed [CB-1:0] dz, logic [15:0] eps);
            t_hit_result e;
            t_wide a, h, c, disc, s, ady;
            e.tag = tag;
            e.hits = HITS_NONE;
            e.t_near = '0;
            e.t_far = '0;
            e.flag = 1'b0;
            if (mode == MODE_SPHERE) begin
                a = t_wide'(dx) * dx + t_wide'(dy) * dy + t_wide'(dz) * dz;
                h = t_wide'(dx) * ox + t_wide'(dy) * oy + t_wide'(dz) * oz;
                c = t_wide'(ox) * ox + t_wide'(oy) * oy + t_wide'(oz) * oz
                    - (t_wide'(1) <<< (2 * FB));
                if (a == 0) begin
                    e.flag = 1'b1;
                end else begin
                    disc = h * h - a * c;
                    if (disc >= 0) begin
                        s = root_floor(disc);
                        e.t_near = sat_quot(-h - s, a, e.flag);
                        e.t_far = sat_quot(-h + s, a, e.flag);
                        e.hits = HITS_SPHERE;
                    end
                end
            end else begin
                ady = (dy < 0) ? -t_wide'(dy) : t_wide'(dy);
                if (ady != 0 && ady >= eps) begin
                    // sign follows -oy/dy
                    if (dy < 0) e.t_near = sat_quot(t_wide'(oy), ady, e.flag);
                    else e.t_near = sat_quot(-t_wide'(oy), ady, e.flag);
                    e.hits = HITS_PLANE;
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_hit_result got);
            t_hit_result e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result tag %0d", got.tag);
                return;
            end
            e = pending.pop_front();
            if (e.tag !== got.tag || e.hits !== got.hits || e.t_near !== got.t_near ||
                e.t_far !== got.t_far || e.flag !== got.flag) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp tag %0d hits %0d near %0d far %0d flag %0d / got %0d %0d %0d %0d %0d",
                             e.tag, e.hits, e.t_near, e.t_far, e.flag,
                             got.tag, got.hits, got.t_near, got.t_far, got.flag);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic i_mode = 1'b0;
    logic [7:0] i_shape_tag = '0;
    logic signed [CB-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [CB-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_valid;
    logic [7:0] o_tag_out;
    logic [1:0] o_hit_count;
    logic signed [CB-1:0] o_t_near, o_t_far;
    logic o_range_flag;

    hit_scoreboard sb = new();
    logic [15:0] epsilon = EPS_RESET;
    bit calm = 1'b0;

    ray_shape_intersection_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_mode(i_mode), .i_shape_tag(i_shape_tag),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .o_valid(o_valid), .o_tag_out(o_tag_out), .o_hit_count(o_hit_count),
        .o_t_near(o_t_near), .o_t_far(o_t_far), .o_range_flag(o_range_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_hit_result got;
        if (i_rst_n && o_valid) begin
            got.tag = o_tag_out;
            got.hits = t_hits'(o_hit_count);
            got.t_near = o_t_near;
            got.t_far = o_t_far;
            got.flag = o_range_flag;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_ray(i_mode, i_shape_tag, i_origin_x, i_origin_y, i_origin_z,
                        i_dir_x, i_dir_y, i_dir_z, epsilon);
    end

    task automatic send_ray(logic mode, logic signed [CB-1:0] ox, logic signed [CB-1:0] oy,
                            logic signed [CB-1:0] oz, logic signed [CB-1:0] dx,
                            logic signed [CB-1:0] dy, logic signed [CB-1:0] dz);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_shape_tag <= 8'($urandom);
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_origin_z <= oz;
        i_dir_x <= dx;
        i_dir_y <= dy;
        i_dir_z <= dz;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        epsilon = v;
        @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 4 << FB)) - (2 << FB);
            2: return CB'($urandom_range(0, 65536)) - 32768;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            4: return '0;
            default: return CB'($urandom_range(0, 20 << FB)) - (10 << FB);
        endcase
    endfunction

    task automatic random_rays(int n);
        logic signed [CB-1:0] ox, oy, oz, dx, dy, dz;
        for (int k = 0; k < n; k++) begin
            ox = pick_coord(); oy = pick_coord(); oz = pick_coord();
            dx = pick_coord(); dy = pick_coord(); dz = pick_coord();
            // well-formed rays aimed back at the origin, in sphere or plane mode
            if ($urandom_range(0, 2) == 0) begin
                dx = -ox >>> $urandom_range(0, 4);
                dy = -oy >>> $urandom_range(0, 4);
                dz = -oz >>> $urandom_range(0, 4);
            end
            send_ray(1'($urandom), ox, oy, oz, dx, dy, dz);
        end
    endtask

    localparam logic signed [CB-1:0] ONE = 1 << FB;
    localparam logic signed [CB-1:0] MAXC = 32'sh7fffffff;
    localparam logic signed [CB-1:0] MINC = 32'sh80000000;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed
        send_ray(MODE_SPHERE, 0, 0, -2 * ONE, 0, 0, ONE);
        send_ray(MODE_SPHERE, ONE, 0, -2 * ONE, 0, 0, ONE);
        send_ray(MODE_SPHERE, 2 * ONE, 0, -2 * ONE, 0, 0, ONE);
        send_ray(MODE_SPHERE, 0, 0, 0, 0, 0, 0);
        send_ray(MODE_SPHERE, 0, 0, 0, 1, 0, 0);
        send_ray(MODE_SPHERE, MAXC, MINC, MAXC, MINC, MAXC, MINC);
        send_ray(MODE_SPHERE, MINC, MINC, MINC, 1, 1, 1);
        send_ray(MODE_SPHERE, MAXC, MAXC, MAXC, -1, -1, -1);
        send_ray(MODE_SPHERE, 0, 0, 0, MAXC, MAXC, MAXC);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, -ONE, 0);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, 0, 0);
        send_ray(MODE_PLANE, 0, MAXC, 0, 0, 1, 0);
        send_ray(MODE_PLANE, 0, MINC, 0, 0, 1, 0);
        send_ray(MODE_PLANE, 0, MINC, 0, 0, MINC, 0);
        send_ray(MODE_PLANE, 0, -ONE, 0, 0, -1, 0);
        send_ray(MODE_PLANE, 0, 5, 0, 0, MAXC, 0);
        drain();
        write_epsilon(16'd0);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, 0, 0);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, 1, 0);
        random_rays(150);
        drain();
        write_epsilon(16'hffff);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, 16'hfffe, 0);
        send_ray(MODE_PLANE, 0, ONE, 0, 0, -32'sh0000ffff, 0);
        random_rays(200);
        drain();
        write_epsilon(16'h0100);
        random_rays(200);
        drain();
        write_epsilon(16'($urandom));
        calm = 1'b1;
        random_rays(150);
        drain();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
